// ----- hdl/tww_pkg.sv -----
// shared types and constants of the word wrap splitter
// no dependencies; imported by tww_front, tww_back and the top level
package tww_pkg;

    localparam int LINE_CAPACITY_DEF = 256;
    localparam int ITEM_DEPTH_DEF    = 4;
    localparam int RESULT_DEPTH_DEF  = 2;

    localparam int POS_W      = 16;
    localparam int LEN_W      = 7;
    localparam int WIDTH_W    = 7;
    localparam int LINES_W    = 9;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0]         CHAR_NEWLINE = 8'd10;
    localparam logic [7:0]         CHAR_SPACE   = 8'd32;
    localparam logic [POS_W-1:0]   POS_LAST     = 16'hFFFF;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN    = 7'd4;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 7'd20;
    localparam logic [LINES_W-1:0] LINES_RESET  = 9'd256;

    // register index, taken from paddr[2]
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_MAX_LINES  = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_SPACE,
        KIND_NEWLINE,
        KIND_END
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] pos;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             valid;
        logic             done;
    } t_result;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [LINES_W-1:0] max_lines;
    } t_cfg;

endpackage

// ----- hdl/tww_fifo.sv -----
// small register fifo, used for the item queue and the result queue
// depends on nothing but its parameters
module tww_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/tww_front.sv -----
// front end: accepts characters, tags each with its text position and kind
// depends on tww_pkg; feeds the item queue
module tww_front
    import tww_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_action,
    input  logic [7:0] i_char_code,
    output logic       o_full,
    output logic       o_item_push,
    output t_item      o_item,
    input  logic       i_item_full
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             accept;
    logic             drop;

    assign o_full = i_item_full;
    assign accept = i_push && !i_item_full;
    // once the position reaches POS_LAST, characters and newlines are ignored
    assign drop   = !i_action && (r_pos == POS_LAST);

    always_comb begin
        o_item.pos = r_pos;
        if (i_action) begin
            o_item.kind = KIND_END;
        end else begin
            case (i_char_code)
                CHAR_NEWLINE: o_item.kind = KIND_NEWLINE;
                CHAR_SPACE:   o_item.kind = KIND_SPACE;
                default:      o_item.kind = KIND_CHAR;
            endcase
        end
    end

    assign o_item_push = accept && !drop;

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_action) begin
                n_pos = '0;
            end else if (!drop) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- hdl/tww_back.sv -----
// back end: segment tracking, break decision and line count, one item a cycle unless results are full
// depends on tww_pkg; reads the item queue and writes the result queue
module tww_back
    import tww_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_item_empty,
    output logic    o_item_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int LinesMax = (1 << LINES_W) - 1;
    localparam int CapClip  = (LINE_CAPACITY > LinesMax) ? LinesMax : LINE_CAPACITY;
    localparam logic [LINES_W-1:0] CapLimit = LINES_W'(CapClip);
    // floor(w / 3) as (w * 171) >> 9, exact for w below 256
    localparam int Div3Recip = 171;
    localparam int Div3Shift = 9;
    localparam int MulW      = WIDTH_W + 8;

    logic [POS_W-1:0]   r_seg_start, n_seg_start;
    logic [POS_W-1:0]   r_last_space, n_last_space;
    logic               r_space_seen, n_space_seen;
    logic               r_line_nonempty, n_line_nonempty;
    logic [LINES_W-1:0] r_lines, n_lines;

    logic [WIDTH_W-1:0] eff_width;
    logic [MulW-1:0]    width_mul;
    logic [WIDTH_W-1:0] third;
    logic [LINES_W-1:0] eff_cap;
    logic               go;
    logic [POS_W-1:0]   seg_len;
    logic [POS_W-1:0]   space_rel;
    logic               soft_ok;
    logic               line_due;
    logic [POS_W-1:0]   line_off;
    logic [LEN_W-1:0]   line_len;
    logic               emit;
    logic               is_end;

    assign eff_width = (i_cfg.width < WIDTH_MIN) ? WIDTH_MIN : i_cfg.width;
    assign width_mul = MulW'(eff_width) * MulW'(Div3Recip);
    assign third     = WIDTH_W'(width_mul >> Div3Shift);
    assign eff_cap   = (i_cfg.max_lines > CapLimit) ? CapLimit : i_cfg.max_lines;

    assign go         = !i_item_empty && !i_res_full;
    assign o_item_pop = go;
    assign is_end     = (i_item.kind == KIND_END);

    assign seg_len   = i_item.pos - r_seg_start;
    // the last space never lies before the segment start while it is valid
    assign space_rel = r_last_space - r_seg_start;
    assign soft_ok   = r_space_seen && (space_rel >= POS_W'(third));

    always_comb begin
        n_seg_start     = r_seg_start;
        n_last_space    = r_last_space;
        n_space_seen    = r_space_seen;
        n_line_nonempty = r_line_nonempty;
        line_due        = 1'b0;
        line_off        = r_seg_start;
        line_len        = LEN_W'(seg_len);
        case (i_item.kind)
            KIND_END, KIND_NEWLINE: begin
                if (seg_len != '0) begin
                    line_due = 1'b1;
                end else if (!r_line_nonempty) begin
                    line_due = 1'b1;
                    line_off = i_item.pos;
                    line_len = '0;
                end
                if (is_end) begin
                    n_seg_start     = '0;
                    n_last_space    = '0;
                    n_space_seen    = 1'b0;
                    n_line_nonempty = 1'b0;
                end else begin
                    n_seg_start     = i_item.pos + 1'b1;
                    n_space_seen    = 1'b0;
                    n_line_nonempty = 1'b0;
                end
            end
            KIND_CHAR, KIND_SPACE: begin
                n_line_nonempty = 1'b1;
                if (seg_len >= POS_W'(eff_width)) begin
                    line_due     = 1'b1;
                    n_space_seen = 1'b0;
                    if (soft_ok) begin
                        // break at the last space and drop it
                        line_len    = LEN_W'(space_rel);
                        n_seg_start = r_last_space + 1'b1;
                        if (i_item.kind == KIND_SPACE) begin
                            n_last_space = i_item.pos;
                            n_space_seen = 1'b1;
                        end
                    end else if (i_item.kind == KIND_SPACE) begin
                        // hard break, the space right after it is skipped
                        n_seg_start = i_item.pos + 1'b1;
                    end else begin
                        n_seg_start = i_item.pos;
                    end
                end else if (i_item.kind == KIND_SPACE) begin
                    n_last_space = i_item.pos;
                    n_space_seen = 1'b1;
                end
            end
            default: begin
                line_due = 1'b0;
            end
        endcase
    end

    assign emit = line_due && (r_lines < eff_cap);

    always_comb begin
        n_lines = r_lines;
        if (is_end) begin
            n_lines = '0;
        end else if (emit) begin
            n_lines = r_lines + 1'b1;
        end
    end

    assign o_res_push   = go && (emit || is_end);
    assign o_res.offset = emit ? line_off : '0;
    assign o_res.length = emit ? line_len : '0;
    assign o_res.valid  = emit;
    assign o_res.done   = is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_start     <= '0;
            r_last_space    <= '0;
            r_space_seen    <= 1'b0;
            r_line_nonempty <= 1'b0;
            r_lines         <= '0;
        end else if (go) begin
            r_seg_start     <= n_seg_start;
            r_last_space    <= n_last_space;
            r_space_seen    <= n_space_seen;
            r_line_nonempty <= n_line_nonempty;
            r_lines         <= n_lines;
        end
    end

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && is_end |-> o_res_push)
        else $error("end marker beat produced no result");

    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> o_item_pop)
        else $error("result written without consuming an item");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && is_end |=> (r_lines == '0) && !r_space_seen && (r_seg_start == '0))
        else $error("state not cleared after end marker");

    a_newline_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (i_item.kind == KIND_NEWLINE)
        |=> (r_seg_start == $past(i_item.pos) + 1'b1) && !r_line_nonempty)
        else $error("newline did not open a fresh segment");

endmodule

// ----- hdl/text_word_wrap_splitter.sv -----
// top level of the word wrap splitter: config registers, front, queues, back
// depends on tww_pkg, tww_fifo, tww_front, tww_back
//
//  channel   direction  handshake              beat contents
//  input     in         push / full            i_action, i_char_code
//  result    out        empty / pop            o_line_offset, o_line_length,
//                                              o_line_valid, o_text_done
//  config    in/out     apb psel/penable       line width at 0x0, max lines at 0x4
//
// one input beat per cycle while the item queue has room; the back end retires one
// queued item per cycle while results have room, updating the segment registers
// each input beat is registered in the item queue, its result in the result queue
// i_rst_n is synchronous; reset clears queues, position and segment state and
// loads width 20 and max lines 256
// a full result queue halts the back end; the item queue then fills and raises full
module text_word_wrap_splitter
    import tww_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int ITEM_DEPTH    = ITEM_DEPTH_DEF,
    parameter int RESULT_DEPTH  = RESULT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [7:0]            i_char_code,
    output logic                  empty,
    input  logic                  pop,
    output logic [POS_W-1:0]      o_line_offset,
    output logic [LEN_W-1:0]      o_line_length,
    output logic                  o_line_valid,
    output logic                  o_text_done,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ItemW   = $bits(t_item);
    localparam int ResultW = $bits(t_result);

    logic [WIDTH_W-1:0] r_width;
    logic [LINES_W-1:0] r_max_lines;
    logic               cfg_write;
    t_cfg               cfg;

    logic    item_push, item_full, item_empty, item_pop;
    t_item   item_in, item_out;
    logic    res_push, res_full;
    t_result res_in, res_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_max_lines <= LINES_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_LINE_WIDTH: r_width     <= pwdata[WIDTH_W-1:0];
                REG_MAX_LINES:  r_max_lines <= pwdata[LINES_W-1:0];
                default:        r_width     <= r_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LINE_WIDTH: prdata = APB_DATA_W'(r_width);
            REG_MAX_LINES:  prdata = APB_DATA_W'(r_max_lines);
            default:        prdata = '0;
        endcase
    end

    assign cfg.width     = r_width;
    assign cfg.max_lines = r_max_lines;

    tww_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .o_full      (full),
        .o_item_push (item_push),
        .o_item      (item_in),
        .i_item_full (item_full)
    );

    tww_fifo #(
        .DATA_W (ItemW),
        .DEPTH  (ITEM_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (item_in),
        .o_full  (item_full),
        .i_pop   (item_pop),
        .o_data  (item_out),
        .o_empty (item_empty)
    );

    tww_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item_out),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    tww_fifo #(
        .DATA_W (ResultW),
        .DEPTH  (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_line_offset = res_out.offset;
    assign o_line_length = res_out.length;
    assign o_line_valid  = res_out.valid;
    assign o_text_done   = res_out.done;

endmodule
